// ----- sv/alamouti_ofdm_combiner_macros.svh -----
`ifndef ALAMOUTI_OFDM_COMBINER_MACROS_SVH
`define ALAMOUTI_OFDM_COMBINER_MACROS_SVH
`ifndef SYNTHESIS
// checked only while out of reset
`define AOC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define AOC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define AOC_ASSERT(label, prop, msg)
`define AOC_ASSERT_RST(label, prop, msg)
`endif
`endif

// ----- sv/aoc_pkg.sv -----
package aoc_pkg;

    localparam int CARRIERS = 200;
    localparam int PAIRS    = CARRIERS / 2;
    localparam int PAIR_W   = $clog2(PAIRS);
    localparam int CHAN_W   = 32;

    localparam int PILOT_NUM = 8;
    localparam int PILOT_CARRIER [PILOT_NUM] = '{24, 44, 64, 84, 124, 144, 164, 184};

    localparam logic signed [15:0] INV_SQRT2_Q15 = 16'sd23170;

    localparam logic [1:0] MARK_PLAIN    = 2'd0;
    localparam logic [1:0] MARK_PREAMBLE = 2'd1;
    localparam logic [1:0] MARK_LOAD_EQ  = 2'd2;

    typedef struct packed {
        logic signed [15:0] rx_even_re;
        logic signed [15:0] rx_even_im;
        logic signed [15:0] rx_odd_re;
        logic signed [15:0] rx_odd_im;
        logic signed [15:0] chan_a_re;
        logic signed [15:0] chan_a_im;
        logic signed [15:0] chan_b_re;
        logic signed [15:0] chan_b_im;
        logic        [1:0]  symbol_mark;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] eq_even_re;
        logic signed [15:0] eq_even_im;
        logic signed [15:0] eq_odd_re;
        logic signed [15:0] eq_odd_im;
        logic               symbol_last;
    } t_out_item;

    // per-stage load strobes, already qualified by the upstream valid
    typedef struct packed {
        logic s2;
        logic s3;
        logic out;
    } t_pipe_en;

endpackage

// ----- sv/alamouti_ofdm_combiner.sv -----
// 2x1 alamouti combiner for an ofdm subcarrier stream, one subcarrier pair per transaction.
// a marked pair stores its two channel estimates in two PAIRS x 32 estimate rams (written at
// accept, registered read issued at accept) and uses them at once; plain pairs use the stored
// ones. a new pair is taken every clock while o_stall is low; each result passes through the input
// register, the products, the combining sums and scaling/rounding into the output
// register. the four stages drain independently, so the input stalls only when all four hold
// a result waiting on the output; symbol_last marks the last pair of each ofdm symbol.
`include "alamouti_ofdm_combiner_macros.svh"

module alamouti_ofdm_combiner (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  aoc_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output aoc_pkg::t_out_item  o_result
);

    import aoc_pkg::*;

    function automatic logic f_is_pilot(input logic [PAIR_W-1:0] idx);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < PILOT_NUM; k++) begin
            if ({idx, 1'b0} == (PAIR_W + 1)'(PILOT_CARRIER[k])) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    logic              r_s1_vld, r_s2_vld, r_s3_vld, r_out_vld;
    logic              ld1, ld2, ld3, ld_out, accept;
    logic [PAIR_W-1:0] r_pair_idx, n_pair_idx;
    logic              n_last;
    t_in_item          r_s1_item;
    logic              r_s1_pilot, r_s1_last;
    logic [CHAN_W-1:0] rd_a, rd_b;
    t_pipe_en          pipe_en;

    // stage load chain, each stage fills when empty or when it moves on
    assign ld_out = !r_out_vld || !i_stall;
    assign ld3    = !r_s3_vld || ld_out;
    assign ld2    = !r_s2_vld || ld3;
    assign ld1    = !r_s1_vld || ld2;
    assign accept = i_valid && ld1;
    assign o_stall = !ld1;
    assign o_valid = r_out_vld;

    assign pipe_en.s2  = ld2 && r_s1_vld;
    assign pipe_en.s3  = ld3 && r_s2_vld;
    assign pipe_en.out = ld_out && r_s3_vld;

    assign n_last     = (r_pair_idx == PAIR_W'(PAIRS - 1));
    assign n_pair_idx = n_last ? '0 : r_pair_idx + PAIR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_s3_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_pair_idx <= '0;
        end else begin
            if (ld1) begin
                r_s1_vld <= i_valid;
            end
            if (ld2) begin
                r_s2_vld <= r_s1_vld;
            end
            if (ld3) begin
                r_s3_vld <= r_s2_vld;
            end
            if (ld_out) begin
                r_out_vld <= r_s3_vld;
            end
            if (accept) begin
                r_pair_idx <= n_pair_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item  <= i_item;
            r_s1_pilot <= f_is_pilot(r_pair_idx);
            r_s1_last  <= n_last;
        end
    end

    aoc_ram #(
        .WIDTH (CHAN_W),
        .DEPTH (PAIRS)
    ) u_chan_a_ram (
        .i_clk     (i_clk),
        .i_wr_en   (accept && (i_item.symbol_mark != MARK_PLAIN)),
        .i_wr_addr (r_pair_idx),
        .i_wr_data ({i_item.chan_a_re, i_item.chan_a_im}),
        .i_rd_en   (accept),
        .i_rd_addr (r_pair_idx),
        .o_rd_data (rd_a)
    );

    aoc_ram #(
        .WIDTH (CHAN_W),
        .DEPTH (PAIRS)
    ) u_chan_b_ram (
        .i_clk     (i_clk),
        .i_wr_en   (accept && (i_item.symbol_mark != MARK_PLAIN)),
        .i_wr_addr (r_pair_idx),
        .i_wr_data ({i_item.chan_b_re, i_item.chan_b_im}),
        .i_rd_en   (accept),
        .i_rd_addr (r_pair_idx),
        .o_rd_data (rd_b)
    );

    aoc_datapath u_datapath (
        .i_clk      (i_clk),
        .i_en       (pipe_en),
        .i_s1_item  (r_s1_item),
        .i_s1_pilot (r_s1_pilot),
        .i_s1_last  (r_s1_last),
        .i_rd_a     (rd_a),
        .i_rd_b     (rd_b),
        .o_result   (o_result)
    );

    `AOC_ASSERT(a_stall_only_full, o_stall |-> (r_s1_vld && r_s2_vld && r_s3_vld && r_out_vld), "input stalled with an empty stage")
    `AOC_ASSERT(a_pair_wrap, (accept && n_last) |=> (r_pair_idx == '0), "pair index did not wrap after last pair")
    `AOC_ASSERT(a_pair_range, r_pair_idx <= PAIR_W'(PAIRS - 1), "pair index out of range")
    `AOC_ASSERT_RST(a_rst_empty, !i_rst_n |=> !(r_s1_vld || r_s2_vld || r_s3_vld || r_out_vld), "pipeline not empty after reset")

endmodule

// ----- sv/aoc_ram.sv -----
module aoc_ram #(
    parameter int  WIDTH  = 32,
    parameter int  DEPTH  = 100,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/aoc_datapath.sv -----
module aoc_datapath (
    input  logic                i_clk,
    input  aoc_pkg::t_pipe_en   i_en,
    input  aoc_pkg::t_in_item   i_s1_item,
    input  logic                i_s1_pilot,
    input  logic                i_s1_last,
    input  logic [31:0]         i_rd_a,
    input  logic [31:0]         i_rd_b,
    output aoc_pkg::t_out_item  o_result
);

    import aoc_pkg::*;

    typedef struct packed {
        logic signed [31:0] rr;
        logic signed [31:0] ii;
        logic signed [31:0] ri;
        logic signed [31:0] ir;
    } t_cprod;

    function automatic t_cprod f_cmul(input logic signed [15:0] xr, input logic signed [15:0] xi,
                                      input logic signed [15:0] yr, input logic signed [15:0] yi);
        t_cprod p;
        p.rr = 32'(xr) * 32'(yr);
        p.ii = 32'(xi) * 32'(yi);
        p.ri = 32'(xr) * 32'(yi);
        p.ir = 32'(xi) * 32'(yr);
        return p;
    endfunction

    function automatic logic signed [32:0] f_re(input t_cprod p);
        return 33'(p.rr) - 33'(p.ii);
    endfunction

    function automatic logic signed [32:0] f_im(input t_cprod p);
        return 33'(p.ri) + 33'(p.ir);
    endfunction

    function automatic logic signed [15:0] f_half(input logic signed [15:0] x);
        logic signed [16:0] t;
        t = 17'(x) + 17'sd1;
        return t[16:1];
    endfunction

    function automatic logic signed [15:0] f_sat(input logic signed [20:0] x);
        logic signed [15:0] y;
        if (x > 21'sd32767) begin
            y = 16'sh7fff;
        end else if (x < -21'sd32768) begin
            y = 16'sh8000;
        end else begin
            y = x[15:0];
        end
        return y;
    endfunction

    function automatic logic signed [15:0] f_rs16(input logic signed [33:0] x);
        logic signed [34:0] t;
        logic signed [18:0] s;
        t = 35'(x) + 35'sd32768;
        s = t[34:16];
        return f_sat(21'(s));
    endfunction

    function automatic logic signed [15:0] f_rs30(input logic signed [49:0] x);
        logic signed [50:0] t;
        logic signed [20:0] s;
        t = 51'(x) + 51'sd536870912;
        s = t[50:30];
        return f_sat(s);
    endfunction

    // stage 2: estimate select and products
    logic               n_load;
    logic signed [15:0] n_ar, n_ai, n_br, n_bi;
    t_cprod             r_s2_p0, r_s2_p1, r_s2_p2, r_s2_p3;
    logic signed [15:0] r_s2_pre [4];
    logic               r_s2_preamble, r_s2_pilot, r_s2_last;

    always_comb begin
        n_load = (i_s1_item.symbol_mark != MARK_PLAIN);
        if (n_load) begin
            n_ar = i_s1_item.chan_a_re;
            n_ai = i_s1_item.chan_a_im;
            n_br = i_s1_item.chan_b_re;
            n_bi = i_s1_item.chan_b_im;
        end else begin
            n_ar = i_rd_a[31:16];
            n_ai = i_rd_a[15:0];
            n_br = i_rd_b[31:16];
            n_bi = i_rd_b[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_s2_p0 <= f_cmul(i_s1_item.rx_even_re, i_s1_item.rx_even_im, n_ar, n_ai);
            r_s2_p1 <= f_cmul(i_s1_item.rx_odd_re, i_s1_item.rx_odd_im, n_br, n_bi);
            r_s2_p2 <= f_cmul(i_s1_item.rx_even_re, i_s1_item.rx_even_im, n_br, n_bi);
            r_s2_p3 <= f_cmul(i_s1_item.rx_odd_re, i_s1_item.rx_odd_im, n_ar, n_ai);
            r_s2_pre[0] <= f_half(i_s1_item.rx_even_re);
            r_s2_pre[1] <= f_half(i_s1_item.rx_even_im);
            r_s2_pre[2] <= f_half(i_s1_item.rx_odd_re);
            r_s2_pre[3] <= f_half(i_s1_item.rx_odd_im);
            r_s2_preamble <= (i_s1_item.symbol_mark == MARK_PREAMBLE);
            r_s2_pilot    <= i_s1_pilot;
            r_s2_last     <= i_s1_last;
        end
    end

    // stage 3: combining sums
    logic signed [32:0] n_p0_re, n_p0_im, n_p1_re, n_p1_im;
    logic signed [32:0] n_p2_re, n_p2_im, n_p3_re, n_p3_im;
    logic signed [33:0] n_s3_v [4];
    logic signed [33:0] r_s3_v [4];
    logic signed [15:0] r_s3_pre [4];
    logic               r_s3_preamble, r_s3_pilot, r_s3_last;

    always_comb begin
        n_p0_re = f_re(r_s2_p0);
        n_p0_im = f_im(r_s2_p0);
        n_p1_re = f_re(r_s2_p1);
        n_p1_im = f_im(r_s2_p1);
        n_p2_re = f_re(r_s2_p2);
        n_p2_im = f_im(r_s2_p2);
        n_p3_re = f_re(r_s2_p3);
        n_p3_im = f_im(r_s2_p3);
        if (r_s2_pilot) begin
            n_s3_v[0] = 34'(n_p0_re);
            n_s3_v[1] = 34'(n_p0_im);
            n_s3_v[2] = -34'(n_p3_re);
            n_s3_v[3] = 34'(n_p3_im);
        end else begin
            n_s3_v[0] = 34'(n_p0_re) + 34'(n_p1_re);
            n_s3_v[1] = 34'(n_p0_im) - 34'(n_p1_im);
            n_s3_v[2] = 34'(n_p2_re) - 34'(n_p3_re);
            n_s3_v[3] = 34'(n_p2_im) + 34'(n_p3_im);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_s3_v        <= n_s3_v;
            r_s3_pre      <= r_s2_pre;
            r_s3_preamble <= r_s2_preamble;
            r_s3_pilot    <= r_s2_pilot;
            r_s3_last     <= r_s2_last;
        end
    end

    // stage 4: pilot scaling, rounding, saturation
    logic signed [49:0] n_odd_re_sc, n_odd_im_sc;
    t_out_item          n_result;
    t_out_item          r_result;

    always_comb begin
        n_odd_re_sc = 50'(r_s3_v[2]) * 50'(INV_SQRT2_Q15);
        n_odd_im_sc = 50'(r_s3_v[3]) * 50'(INV_SQRT2_Q15);
        n_result.symbol_last = r_s3_last;
        if (r_s3_preamble) begin
            n_result.eq_even_re = r_s3_pre[0];
            n_result.eq_even_im = r_s3_pre[1];
            n_result.eq_odd_re  = r_s3_pre[2];
            n_result.eq_odd_im  = r_s3_pre[3];
        end else begin
            n_result.eq_even_re = f_rs16(r_s3_v[0]);
            n_result.eq_even_im = f_rs16(r_s3_v[1]);
            if (r_s3_pilot) begin
                n_result.eq_odd_re = f_rs30(n_odd_re_sc);
                n_result.eq_odd_im = f_rs30(n_odd_im_sc);
            end else begin
                n_result.eq_odd_re = f_rs16(r_s3_v[2]);
                n_result.eq_odd_im = f_rs16(r_s3_v[3]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.out) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule
